### hw/rtl/sha_pkg.sv
// Shared types, constants and round functions of the SHA-256 stream hasher.
// No dependencies.
package sha_pkg;

  localparam int WordW = 32;
  localparam int MaxLenW = 61;

  localparam logic [1:0] REQ_BYTE     = 2'd0;
  localparam logic [1:0] REQ_FINALIZE = 2'd1;
  localparam logic [1:0] REQ_RESTART  = 2'd2;

  localparam logic [1:0] LIFE_ACTIVE    = 2'd0;
  localparam logic [1:0] LIFE_FINALIZED = 2'd1;
  localparam logic [1:0] LIFE_FAILED    = 2'd2;

  localparam logic [MaxLenW-1:0] MAX_LENGTH = {MaxLenW{1'b1}};

  typedef logic [WordW-1:0] word_t;

  function automatic word_t init_h(input logic [2:0] i);
    word_t r;
    unique case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t r;
    unique case (t)
      6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
      6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
      6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
      6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
      6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic word_t rotr(input word_t v, input int n);
    return (v >> n) | (v << (WordW - n));
  endfunction

endpackage

### hw/rtl/sha_round.sv
// One SHA-256 round plus one message schedule step, reused 64 times per block.
// Depends on sha_pkg.
module sha_round (
  input  logic           clk,
  input  logic           load,       // copy chain words into working vars
  input  logic           step,       // run one round
  input  logic [5:0]     t,
  input  sha_pkg::word_t blk_word,   // message word for rounds 0..15
  input  sha_pkg::word_t chain [8],
  output sha_pkg::word_t vars [8]
);
  import sha_pkg::*;

  word_t v_r [8];
  word_t w_r [16];
  word_t w_new, s0, s1, p15, p2, e, a, big_s1, ch, t1, big_s0, mj;

  always_comb begin
    p15 = w_r[4'(t - 6'd15)];
    p2  = w_r[4'(t - 6'd2)];
    s0  = rotr(p15, 7) ^ rotr(p15, 18) ^ (p15 >> 3);
    s1  = rotr(p2, 17) ^ rotr(p2, 19) ^ (p2 >> 10);
    w_new = (t < 6'd16) ? blk_word : (w_r[t[3:0]] + s0 + w_r[4'(t - 6'd7)] + s1);
    e = v_r[4];
    a = v_r[0];
    big_s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    ch = (e & v_r[5]) ^ (~e & v_r[6]);
    t1 = v_r[7] + big_s1 + ch + round_k(t) + w_new;
    big_s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    mj = (a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 8; i++) v_r[i] <= chain[i];
    end else if (step) begin
      w_r[t[3:0]] <= w_new;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + big_s0 + mj;
    end
  end

  assign vars = v_r;
endmodule

### hw/rtl/sha256_stream_hasher.sv
// SHA-256 stream hasher top level: byte buffer, padding sequencer, digest output.
// Depends on sha_pkg and sha_round.
// A message byte that does not fill the 64-byte block is taken and the hasher
// stays ready. The byte that fills a block starts a compression on one shared
// round unit (load, rounds, chain update), during which in_tready is low. Finalize
// writes the padding one byte per cycle, runs one or two compressions, then offers
// eight digest words on the output, one per transfer;
// a failed finalize skips padding and compression and offers eight zero words.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [1:0] req_type, [9:2] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index
  output logic        out_tlast,  // last
  output logic [2:0]  out_tuser   // [0] ok, [2:1] lifecycle
);
  import sha_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_RND  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_PAD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  word_t              buf_r [16];   // block held as big-endian words
  logic [5:0]         cnt_r;
  logic [MaxLenW-1:0] len_r;
  logic [1:0]         life_r;
  word_t              chain_r [8];
  logic [5:0]         t_r;
  logic               fin_r;    // compression belongs to finalize
  logic               tail_r;   // length block still to be padded
  logic [2:0]         oidx_r;
  logic               ook_r;
  word_t              vars [8];
  word_t              blk_word;
  logic [1:0]         req;
  logic [7:0]         dbyte;
  logic [MaxLenW+2:0] bits;
  logic [7:0]         pad_byte;
  logic               acc;

  assign req   = in_tdata[1:0];
  assign dbyte = in_tdata[9:2];
  assign acc   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign bits = {len_r, 3'b000};
  assign blk_word = buf_r[t_r[3:0]];

  // padding byte at position cnt_r of the current block
  always_comb begin
    pad_byte = 8'h00;
    if (tail_r && cnt_r >= 6'd56) pad_byte = bits[8*(63 - cnt_r) +: 8];
  end

  sha_round u_round (
    .clk(clk), .load(state_r == ST_LOAD), .step(state_r == ST_RND),
    .t(t_r), .blk_word(blk_word), .chain(chain_r), .vars(vars)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (acc) begin
        if (req == REQ_BYTE && life_r == LIFE_ACTIVE && len_r != MAX_LENGTH &&
            cnt_r == 6'd63) state_nxt = ST_LOAD;
        else if (req == REQ_FINALIZE) begin
          if (life_r != LIFE_ACTIVE) state_nxt = ST_OUT;
          else if (cnt_r == 6'd63) state_nxt = ST_LOAD;
          else state_nxt = ST_PAD;
        end
      end
      ST_LOAD: state_nxt = ST_RND;
      ST_RND:  if (t_r == 6'd63) state_nxt = ST_ADD;
      ST_ADD:  state_nxt = fin_r ? (tail_r ? ST_OUT : ST_PAD) : ST_IDLE;
      ST_PAD: begin
        if (cnt_r == 6'd63) state_nxt = ST_LOAD;
      end
      ST_OUT: if (out_tready && oidx_r == 3'd7) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      len_r <= '0;
      life_r <= LIFE_ACTIVE;
      t_r <= '0;
      fin_r <= 1'b0;
      tail_r <= 1'b0;
      oidx_r <= '0;
      ook_r <= 1'b0;
      for (int i = 0; i < 8; i++) chain_r[i] <= init_h(3'(i));
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: if (acc) begin
          unique case (req)
            REQ_BYTE: begin
              if (life_r != LIFE_ACTIVE || len_r == MAX_LENGTH) life_r <= LIFE_FAILED;
              else begin
                len_r <= len_r + 1'b1;
                buf_r[cnt_r[5:2]][{~cnt_r[1:0], 3'b000} +: 8] <= dbyte;
                cnt_r <= cnt_r + 1'b1;
                fin_r <= 1'b0;
              end
            end
            REQ_FINALIZE: begin
              oidx_r <= '0;
              if (life_r != LIFE_ACTIVE) begin
                life_r <= LIFE_FAILED;
                ook_r <= 1'b0;
              end else begin
                buf_r[cnt_r[5:2]][{~cnt_r[1:0], 3'b000} +: 8] <= 8'h80;
                cnt_r <= cnt_r + 1'b1;
                fin_r <= 1'b1;
                // length fits in this block only if 0x80 lands before byte 56
                tail_r <= (cnt_r < 6'd56);
              end
            end
            REQ_RESTART: begin
              cnt_r <= '0;
              len_r <= '0;
              life_r <= LIFE_ACTIVE;
              for (int i = 0; i < 8; i++) chain_r[i] <= init_h(3'(i));
            end
            default: ;
          endcase
        end
        ST_LOAD: t_r <= '0;
        ST_RND:  t_r <= t_r + 1'b1;
        ST_ADD: begin
          for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + vars[i];
          if (fin_r && tail_r) begin
            life_r <= LIFE_FINALIZED;
            ook_r <= 1'b1;
          end
          // second block of a two-block pad carries the length
          if (fin_r) tail_r <= !tail_r;
        end
        ST_PAD: begin
          buf_r[cnt_r[5:2]][{~cnt_r[1:0], 3'b000} +: 8] <= pad_byte;
          cnt_r <= cnt_r + 1'b1;
        end
        ST_OUT: if (out_tready) oidx_r <= oidx_r + 1'b1;
        default: ;
      endcase
    end
  end

  // ST_ADD sets tail_r for the next pass: if tail was clear it becomes set (pad
  // another block with length); if set, this was the length block -> output.
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {5'd0, oidx_r, ook_r ? chain_r[oidx_r] : 32'd0};
  assign out_tlast  = (oidx_r == 3'd7);
  assign out_tuser  = {life_r, ook_r};

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("ready while busy");
  a_out_ok_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ook_r) |-> (life_r == LIFE_FINALIZED)) else $error("ok not final");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !ook_r) |-> (out_tdata[31:0] == 32'd0 && life_r == LIFE_FAILED))
    else $error("failed word not zero");
endmodule

### test/sha256_stream_hasher_tb.sv
// Self-checking testbench for the SHA-256 stream hasher: directed and random
// byte/finalize/restart streams against an in-bench SHA-256 model.
// Depends on sha_pkg and the sha256_stream_hasher RTL.
module sha256_stream_hasher_tb;
  import sha_pkg::*;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
    logic        ok;
    logic [1:0]  lifecycle;
  } digest_beat_t;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic [2:0]  out_tuser;

  sha256_stream_hasher u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  // model state
  word_t       hash_h[8];
  logic [7:0]  msg_buf[64];
  int unsigned buf_cnt;
  logic [60:0] msg_len;
  logic [1:0]  life;

  digest_beat_t digest_q[$];
  int errors;
  int beats_seen;
  int digests_sent;
  int hold_cycles;
  logic rx_random;

  localparam word_t K_TAB[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam word_t IV_TAB[8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic word_t ror32(word_t v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress_block();
    word_t w[64];
    word_t v[8];
    word_t s0, s1, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_buf[4*t], msg_buf[4*t+1], msg_buf[4*t+2], msg_buf[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_h[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[t] + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] = hash_h[i] + v[i];
  endtask

  task automatic model_restart();
    for (int i = 0; i < 8; i++) hash_h[i] = IV_TAB[i];
    buf_cnt = 0;
    msg_len = '0;
    life = LIFE_ACTIVE;
  endtask

  // advance the model by one accepted item and queue the digest beats it causes
  task automatic predict_hash(logic [1:0] req, logic [7:0] data);
    logic [63:0] bits;
    int unsigned n;
    digest_beat_t b;
    case (req)
      REQ_BYTE: begin
        if (life != LIFE_ACTIVE || msg_len == MAX_LENGTH) begin
          life = LIFE_FAILED;
        end else begin
          msg_len++;
          msg_buf[buf_cnt] = data;
          buf_cnt++;
          if (buf_cnt == 64) begin
            compress_block();
            buf_cnt = 0;
          end
        end
      end
      REQ_RESTART: model_restart();
      REQ_FINALIZE: begin
        if (life != LIFE_ACTIVE) begin
          life = LIFE_FAILED;
          for (int k = 0; k < 8; k++) begin
            b = '{32'd0, 3'(k), k == 7, 1'b0, LIFE_FAILED};
            digest_q.push_back(b);
          end
        end else begin
          bits = {msg_len, 3'b000};
          n = buf_cnt;
          msg_buf[n] = 8'h80;
          n++;
          if (n > 56) begin
            while (n < 64) begin msg_buf[n] = 8'h00; n++; end
            compress_block();
            n = 0;
          end
          while (n < 56) begin msg_buf[n] = 8'h00; n++; end
          for (int k = 0; k < 8; k++) msg_buf[63-k] = bits[8*k +: 8];
          compress_block();
          buf_cnt = 0;
          life = LIFE_FINALIZED;
          for (int k = 0; k < 8; k++) begin
            b = '{hash_h[k], 3'(k), k == 7, 1'b1, LIFE_FINALIZED};
            digest_q.push_back(b);
          end
        end
        digests_sent++;
      end
      default: ;
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("%0t timeout", $time);
    $display("sha256_stream_hasher_tb: done, errors");
    $finish;
  end

  task automatic send_item(logic [1:0] req, logic [7:0] data, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {6'd0, data, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_hash(req, data);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // receiver: always ready, random stalls when rx_random is set, or a long hold-off when hold_cycles is set
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else if (rx_random) begin
        stall = $urandom_range(0, 15);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
        while (!out_tvalid) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    digest_beat_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[31:0], out_tdata[34:32], out_tlast, out_tuser[0], out_tuser[2:1]};
      beats_seen++;
      if (digest_q.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = digest_q.pop_front();
        if (got.digest_word !== want.digest_word)
          $display("%0t digest_word: expected %h, actual %h", $time, want.digest_word,
                   got.digest_word);
        if (got.word_index !== want.word_index)
          $display("%0t word_index: expected %0d, actual %0d", $time, want.word_index,
                   got.word_index);
        if (got.last !== want.last)
          $display("%0t last: expected %b, actual %b", $time, want.last, got.last);
        if (got.ok !== want.ok)
          $display("%0t ok: expected %b, actual %b", $time, want.ok, got.ok);
        if (got.lifecycle !== want.lifecycle)
          $display("%0t lifecycle: expected %0d, actual %0d", $time, want.lifecycle,
                   got.lifecycle);
        if (got !== want) errors++;
      end
    end
  end

  task automatic send_bytes(int count);
    for (int i = 0; i < count; i++) send_item(REQ_BYTE, 8'($urandom));
  endtask

  // empty message, a short message with extreme byte values, an unused request type
  task automatic test_directed();
    send_item(REQ_FINALIZE, 8'h00);
    send_item(REQ_RESTART, 8'h00);
    send_item(REQ_BYTE, 8'h00);
    send_item(REQ_BYTE, 8'hff);
    send_item(REQ_BYTE, 8'haa);
    send_item(REQ_BYTE, 8'h55);
    send_item(REQ_UNUSED, 8'hff);
    send_item(REQ_FINALIZE, 8'hff);
    send_item(REQ_RESTART, 8'hff);
  endtask

  // misuse: byte after finalize, finalize after finalize, finalize while failed
  task automatic test_misuse();
    send_item(REQ_FINALIZE, 8'h00);
    send_item(REQ_FINALIZE, 8'h00);
    send_item(REQ_BYTE, 8'h12);
    send_item(REQ_FINALIZE, 8'h00);
    send_item(REQ_RESTART, 8'h00);
    send_item(REQ_BYTE, 8'h34);
    send_item(REQ_FINALIZE, 8'h00);
    send_item(REQ_BYTE, 8'h56);
    send_item(REQ_FINALIZE, 8'h00);
    send_item(REQ_RESTART, 8'h00);
  endtask

  // one-block and two-block padding cases; 64 bytes exercises a full block
  task automatic test_block_boundaries();
    int lens[4] = '{55, 56, 63, 64};
    foreach (lens[i]) begin
      send_bytes(lens[i]);
      send_item(REQ_FINALIZE, 8'h00);
      send_item(REQ_RESTART, 8'h00);
    end
  endtask

  // long receiver hold-off while finalizes keep coming in
  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 6; i++) begin
      send_bytes($urandom_range(0, 3));
      send_item(REQ_FINALIZE, 8'h00, 1);
      send_item(REQ_RESTART, 8'h00, 1);
    end
  endtask

  task automatic test_random(int items);
    int sent;
    int r;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(0, 9);
      if (r < 8) begin
        // well-formed message of 0 to 12 random bytes
        send_bytes($urandom_range(0, 12));
        send_item(REQ_FINALIZE, 8'h00);
        send_item(REQ_RESTART, 8'h00);
        sent += 8;
      end else begin
        send_item(2'($urandom), 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    int drain;
    errors = 0;
    beats_seen = 0;
    digests_sent = 0;
    hold_cycles = 0;
    rx_random = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    rst_n = 1'b0;
    model_restart();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_misuse();
    test_block_boundaries();
    rx_random = 1'b1;
    test_backpressure();
    test_random(45);
    drain = 0;
    while (digest_q.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (200) @(posedge clk);
    if (digest_q.size() != 0) begin
      $display("%0t %0d digest beats never arrived", $time, digest_q.size());
      errors++;
    end
    $display("covered %0d finalizes, %0d digest beats, padding edges, misuse, hold-off",
             digests_sent, beats_seen);
    if (errors == 0) begin
      $display("sha256_stream_hasher_tb: done, clean");
    end else begin
      $display("sha256_stream_hasher_tb: done, errors");
    end
    $finish;
  end

endmodule
